// ----- rtl/aal_pkg.sv -----
// Shared types, codes and helpers for the attentional associative learning block.
// Used by aal_cell and the top level; depends on nothing else.
package aal_pkg;

  // Trial control codes carried in the trial_control field.
  localparam logic [2:0] CTL_LEARN     = 3'd0;
  localparam logic [2:0] CTL_RESET_ALL = 3'd1;
  localparam logic [2:0] CTL_PREDICT   = 3'd2;
  localparam logic [2:0] CTL_RESET_W   = 3'd3;
  localparam logic [2:0] CTL_RESET_A   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEARN_RATE = 3'd0;
  localparam logic [2:0] REG_ATTN_RATE  = 3'd1;
  localparam logic [2:0] REG_INIT_W     = 3'd2;
  localparam logic [2:0] REG_INIT_A     = 3'd3;
  localparam logic [2:0] REG_TRACE_EN   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [12:0]        RATE_RST  = 13'd410;
  localparam logic signed [15:0] ALPHA_RST = 16'sh1000;

  // Phase strobes that the sequencer sends to every cell.
  typedef struct packed {
    logic x_load;      // capture the cue activation of a new request
    logic load_w;      // reload the weight from its initial value
    logic load_a;      // reload the attention value from its initial value
    logic mul1;        // product of activation and weight, learning gain
    logic sum;         // weight delta
    logic mul2;        // weight step and attention gain
    logic mul3;        // attention step
    logic upd;         // write back weight and attention
    logic learn;       // trial is not predict only
    logic trace_load;  // copy the state into the trace chain
    logic trace_shift; // move the trace chain one cell toward cell 0
  } cell_ctl_t;

  // Saturate a signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/aal_cell.sv -----
// One cue cell: weight and attention state, the per-cue multiplies and a trace stage.
// Depends on aal_pkg for the control struct and saturation.
module aal_cell #(
  parameter int FRAC_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  aal_pkg::cell_ctl_t        ctl,
  input  logic signed [15:0]        cue_i,
  input  logic signed [15:0]        t_i,
  input  logic signed [15:0]        sum_i,
  input  logic [12:0]               lr_i,
  input  logic [12:0]               ar_i,
  input  logic signed [15:0]        init_w_i,
  input  logic signed [15:0]        init_a_i,
  input  logic signed [17:0]        psum_i,
  output logic signed [17:0]        psum_o,
  input  logic signed [15:0]        trw_i,
  input  logic signed [15:0]        tra_i,
  output logic signed [15:0]        trw_o,
  output logic signed [15:0]        tra_o
);

  localparam int GW   = 30 - FRAC_BITS;      // learning gain width
  localparam int WSW  = 32 - FRAC_BITS;      // weight step width
  localparam int HW   = 34 - FRAC_BITS;      // attention gain width
  localparam int AW   = 50 - 2 * FRAC_BITS;  // attention step width
  localparam int AMAX = 1 << FRAC_BITS;
  localparam int AMIN = ((1 << FRAC_BITS) + 5) / 10;

  logic signed [15:0]     x_r, x_nxt;
  logic signed [15:0]     w_r, w_nxt;
  logic signed [15:0]     a_r, a_nxt;
  logic signed [15:0]     act_r, act_nxt;
  logic signed [GW-1:0]   g_r, g_nxt;
  logic signed [15:0]     delta_r, delta_nxt;
  logic signed [WSW-1:0]  wstep_r, wstep_nxt;
  logic signed [HW-1:0]   h_r, h_nxt;
  logic signed [AW-1:0]   astep_r, astep_nxt;
  logic signed [15:0]     trw_r, trw_nxt;
  logic signed [15:0]     tra_r, tra_nxt;

  logic signed [31:0]     prod_act;
  logic signed [29:0]     prod_g;
  logic signed [16:0]     e2;
  logic signed [GW+16:0]  prod_d;
  logic signed [17:0]     e1;
  logic signed [18:0]     mag1, mag2;
  logic signed [19:0]     d;
  logic signed [33:0]     prod_h;
  logic signed [31:0]     prod_ws;
  logic signed [HW+15:0]  prod_as;
  logic signed [32:0]     w_sum;
  logic signed [AW-1:0]   astep_eff;
  logic signed [AW:0]     a_sum;

  // First multiply stage: prediction term and learning gain.
  assign prod_act = 32'(x_r) * 32'(w_r);
  assign prod_g   = 30'($signed({1'b0, lr_i})) * 30'(a_r);

  // Partial prediction sum ripples through the row.
  assign psum_o = psum_i + 18'(act_r);

  // Weight delta from the cue's own error.
  assign e2     = 17'(t_i) - 17'(act_r);
  assign prod_d = (GW+17)'(g_r) * (GW+17)'(e2);

  // Attention gain from the difference of absolute errors.
  assign e1   = 18'(t_i) - (18'(sum_i) - 18'(act_r));
  assign mag1 = (e1 < 0) ? -19'(e1) : 19'(e1);
  assign mag2 = (e2 < 0) ? -19'(e2) : 19'(e2);
  assign d    = 20'(mag1) - 20'(mag2);
  assign prod_h  = 34'($signed({1'b0, ar_i})) * 34'(d);
  assign prod_ws = 32'(delta_r) * 32'(x_r);

  // Attention step.
  assign prod_as = (HW+16)'(h_r) * (HW+16)'(x_r);

  // Write-back arithmetic.
  assign w_sum     = 33'(w_r) + 33'(wstep_r);
  assign astep_eff = ctl.learn ? astep_r : '0;
  assign a_sum     = (AW+1)'(a_r) + (AW+1)'(astep_eff);

  // Next-state selection for all cell registers.
  always_comb begin
    x_nxt     = ctl.x_load ? cue_i : x_r;
    act_nxt   = act_r;
    g_nxt     = g_r;
    delta_nxt = delta_r;
    wstep_nxt = wstep_r;
    h_nxt     = h_r;
    astep_nxt = astep_r;
    w_nxt     = w_r;
    a_nxt     = a_r;
    trw_nxt   = trw_r;
    tra_nxt   = tra_r;

    if (ctl.mul1) begin
      act_nxt = aal_pkg::sat16(40'(prod_act >>> FRAC_BITS));
      g_nxt   = prod_g[29:FRAC_BITS];
    end
    if (ctl.sum) begin
      delta_nxt = aal_pkg::sat16(40'(prod_d >>> FRAC_BITS));
    end
    if (ctl.mul2) begin
      h_nxt     = prod_h[33:FRAC_BITS];
      wstep_nxt = prod_ws[31:FRAC_BITS];
    end
    if (ctl.mul3) begin
      astep_nxt = prod_as[HW+15:FRAC_BITS];
    end

    // Weight: reload on a reset code, update unless predict only.
    if (ctl.load_w) begin
      w_nxt = init_w_i;
    end else if (ctl.upd && ctl.learn) begin
      w_nxt = aal_pkg::sat16(40'(w_sum));
    end

    // Attention: reload on a reset code, always clamp at write-back.
    if (ctl.load_a) begin
      a_nxt = init_a_i;
    end else if (ctl.upd) begin
      if (a_sum > (AW+1)'(AMAX)) begin
        a_nxt = 16'(AMAX);
      end else if (a_sum < (AW+1)'(AMIN)) begin
        a_nxt = 16'(AMIN);
      end else begin
        a_nxt = a_sum[15:0];
      end
    end

    // Trace chain: load the state, or take the neighbor's entry.
    if (ctl.trace_load) begin
      trw_nxt = w_r;
      tra_nxt = a_r;
    end else if (ctl.trace_shift) begin
      trw_nxt = trw_i;
      tra_nxt = tra_i;
    end
  end

  // Learned state resets to the reset values of the initial registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
      a_r <= aal_pkg::ALPHA_RST;
    end else begin
      w_r <= w_nxt;
      a_r <= a_nxt;
    end
  end

  // Working and trace registers.
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    act_r   <= act_nxt;
    g_r     <= g_nxt;
    delta_r <= delta_nxt;
    wstep_r <= wstep_nxt;
    h_r     <= h_nxt;
    astep_r <= astep_nxt;
    trw_r   <= trw_nxt;
    tra_r   <= tra_nxt;
  end

  assign trw_o = trw_r;
  assign tra_o = tra_r;

`ifndef ASSERT_OFF
  // After a write-back the attention value lies inside the clamp range.
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.upd |=> (a_r >= 16'(AMIN)) && (a_r <= 16'(AMAX)))
    else $error("attention value outside clamp range after update");
`endif

endmodule

// ----- rtl/attentional_associative_learning.sv -----
// Attentional associative learning block: a trial takes a control code, four
// cue activations and a teacher value, and returns the summed prediction made
// with the weights held before its update, then updates one weight and one
// attention value per cue in a row of NUM_CUES cells. The datapath steps
// through accept, first multiply, prediction sum, second multiply, attention
// multiply and write-back, in an order set by the chain of dependent
// multiplies inside each cell; a new request is taken in the hand-off state
// that follows write-back. Each trial yields one prediction record, or with
// tracing one prediction record and NUM_CUES trace records, which drain from
// the output register one per cycle when out_stall is low, while the next
// trial runs. A finished trial waits after write-back, with new requests held
// off, only if the previous trial still has records to deliver. Register
// writes to the initial values take effect at the next reset control code.
// Depends on aal_pkg and aal_cell.
module attentional_associative_learning #(
  parameter int NUM_CUES  = 4,
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata,
  // trial requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_trial_control,
  input  logic signed [15:0] in_cue_0,
  input  logic signed [15:0] in_cue_1,
  input  logic signed [15:0] in_cue_2,
  input  logic signed [15:0] in_cue_3,
  input  logic signed [15:0] in_teacher,
  // result records
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_record_kind,
  output logic signed [15:0] out_summed_prediction,
  output logic [1:0]         out_cue_index,
  output logic signed [15:0] out_cue_weight,
  output logic [12:0]        out_cue_alpha,
  output logic               out_last
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_MUL3 = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_HAND = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;

  logic [12:0]        lr_r, lr_nxt;
  logic [12:0]        ar_r, ar_nxt;
  logic [63:0]        initw_r, initw_nxt;
  logic [63:0]        inita_r, inita_nxt;
  logic               trace_en_r, trace_en_nxt;

  logic [2:0]         ctrl_r, ctrl_nxt;
  logic signed [15:0] t_r, t_nxt;
  logic signed [15:0] sum_r, sum_nxt;

  logic               busy_r, busy_nxt;
  logic               kind_r, kind_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               trace_r, trace_nxt;
  logic signed [15:0] pred_r, pred_nxt;

  logic               in_acc, out_acc, hand, idx_end;
  aal_pkg::cell_ctl_t ctl;

  logic signed [15:0] cue_in [4];
  logic signed [17:0] psum [NUM_CUES+1];
  logic signed [15:0] trw  [NUM_CUES+1];
  logic signed [15:0] tra  [NUM_CUES+1];

  // Handshakes.
  assign hand     = (st_r == ST_HAND) && !busy_r;
  assign in_stall = !((st_r == ST_IDLE) || hand);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign idx_end  = (idx_r == 2'(NUM_CUES - 1));

  // Configuration register writes.
  always_comb begin
    lr_nxt       = lr_r;
    ar_nxt       = ar_r;
    initw_nxt    = initw_r;
    inita_nxt    = inita_r;
    trace_en_nxt = trace_en_r;
    if (cfg_we) begin
      unique case (cfg_index)
        aal_pkg::REG_LEARN_RATE: lr_nxt       = cfg_wdata[12:0];
        aal_pkg::REG_ATTN_RATE:  ar_nxt       = cfg_wdata[12:0];
        aal_pkg::REG_INIT_W:     initw_nxt    = cfg_wdata;
        aal_pkg::REG_INIT_A:     inita_nxt    = cfg_wdata;
        aal_pkg::REG_TRACE_EN:   trace_en_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r       <= aal_pkg::RATE_RST;
      ar_r       <= aal_pkg::RATE_RST;
      initw_r    <= '0;
      inita_r    <= {4{aal_pkg::ALPHA_RST}};
      trace_en_r <= 1'b0;
    end else begin
      lr_r       <= lr_nxt;
      ar_r       <= ar_nxt;
      initw_r    <= initw_nxt;
      inita_r    <= inita_nxt;
      trace_en_r <= trace_en_nxt;
    end
  end

  // Trial sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_MUL1;
      ST_MUL1: st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_MUL2;
      ST_MUL2: st_nxt = ST_MUL3;
      ST_MUL3: st_nxt = ST_UPD;
      ST_UPD:  st_nxt = ST_HAND;
      ST_HAND: begin
        if (!busy_r) begin
          st_nxt = in_acc ? ST_MUL1 : ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Trial fields and the registered prediction sum.
  assign ctrl_nxt = in_acc ? in_trial_control : ctrl_r;
  assign t_nxt    = in_acc ? in_teacher : t_r;
  assign sum_nxt  = (st_r == ST_SUM) ? aal_pkg::sat16(40'(psum[NUM_CUES])) : sum_r;

  always_ff @(posedge clk) begin
    ctrl_r <= ctrl_nxt;
    t_r    <= t_nxt;
    sum_r  <= sum_nxt;
  end

  // Phase strobes for the cell row.
  always_comb begin
    ctl.x_load      = in_acc;
    ctl.load_w      = in_acc && ((in_trial_control == aal_pkg::CTL_RESET_ALL) ||
                                 (in_trial_control == aal_pkg::CTL_RESET_W));
    ctl.load_a      = in_acc && ((in_trial_control == aal_pkg::CTL_RESET_ALL) ||
                                 (in_trial_control == aal_pkg::CTL_RESET_A));
    ctl.mul1        = (st_r == ST_MUL1);
    ctl.sum         = (st_r == ST_SUM);
    ctl.mul2        = (st_r == ST_MUL2);
    ctl.mul3        = (st_r == ST_MUL3);
    ctl.upd         = (st_r == ST_UPD);
    ctl.learn       = (ctrl_r != aal_pkg::CTL_PREDICT);
    ctl.trace_load  = hand;
    ctl.trace_shift = out_acc && kind_r;
  end

  // Row of cue cells.
  assign cue_in[0]      = in_cue_0;
  assign cue_in[1]      = in_cue_1;
  assign cue_in[2]      = in_cue_2;
  assign cue_in[3]      = in_cue_3;
  assign psum[0]        = '0;
  assign trw[NUM_CUES]  = '0;
  assign tra[NUM_CUES]  = '0;

  for (genvar k = 0; k < NUM_CUES; k++) begin : g_cell
    aal_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cue_i    (cue_in[k]),
      .t_i      (t_r),
      .sum_i    (sum_r),
      .lr_i     (lr_r),
      .ar_i     (ar_r),
      .init_w_i (initw_r[16*k +: 16]),
      .init_a_i (inita_r[16*k +: 16]),
      .psum_i   (psum[k]),
      .psum_o   (psum[k+1]),
      .trw_i    (trw[k+1]),
      .tra_i    (tra[k+1]),
      .trw_o    (trw[k]),
      .tra_o    (tra[k])
    );
  end

  // Record drain: prediction record first, then the trace chain.
  always_comb begin
    busy_nxt  = busy_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    trace_nxt = trace_r;
    pred_nxt  = pred_r;
    if (hand) begin
      busy_nxt  = 1'b1;
      kind_nxt  = 1'b0;
      idx_nxt   = '0;
      trace_nxt = trace_en_r;
      pred_nxt  = sum_r;
    end else if (out_acc) begin
      if (!kind_r) begin
        if (trace_r) begin
          kind_nxt = 1'b1;
        end else begin
          busy_nxt = 1'b0;
        end
      end else if (idx_end) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      kind_r  <= 1'b0;
      idx_r   <= '0;
      trace_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      trace_r <= trace_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pred_r <= pred_nxt;
  end

  // Result fields come straight from registers.
  assign out_valid             = busy_r;
  assign out_record_kind       = kind_r;
  assign out_summed_prediction = kind_r ? '0 : pred_r;
  assign out_cue_index         = kind_r ? idx_r : '0;
  assign out_cue_weight        = kind_r ? trw[0] : '0;
  assign out_cue_alpha         = kind_r ? tra[0][12:0] : '0;
  assign out_last              = kind_r ? idx_end : !trace_r;

`ifndef ASSERT_OFF
  // Requests are taken only when the datapath is free.
  in_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ((st_r == ST_IDLE) || (st_r == ST_HAND)))
    else $error("request accepted while the datapath is busy");

  // A handoff always starts with the prediction record.
  hand_starts_pred: assert property (@(posedge clk) disable iff (!rst_n)
    hand |=> (busy_r && !kind_r))
    else $error("handoff did not start a prediction record");

  // Trace records appear only for a trial that was traced.
  trace_only_traced: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && kind_r) |-> trace_r)
    else $error("trace record without tracing");

  // The trace chain moves only while trace records drain.
  shift_only_trace: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.trace_shift |-> (busy_r && !hand))
    else $error("trace chain shifted outside a drain");
`endif

endmodule
